### rtl/core/pmcf_pkg.sv
// Package for the PNG metadata chunk filter: chunk type codes and a type match helper.
// No dependencies; used by png_metadata_chunk_filter.
package pmcf_pkg;

    localparam int unsigned NumStripTypes = 6;
    localparam int unsigned HdrHoldDepth  = 7;
    localparam int unsigned BodyWidth     = 33;

    // Chunk types that may be stripped, bit order of the drop mask
    localparam logic [NumStripTypes-1:0][31:0] STRIP_TYPES = '{
        32'h7048_5973,  // pHYs, mask bit 5
        32'h7449_4D45,  // tIME, mask bit 4
        32'h6558_4966,  // eXIf, mask bit 3
        32'h6954_5874,  // iTXt, mask bit 2
        32'h7A54_5874,  // zTXt, mask bit 1
        32'h7445_5874   // tEXt, mask bit 0
    };

    localparam logic [31:0] IEND_TYPE = 32'h4945_4E44;

    localparam logic [NumStripTypes-1:0] DROP_MASK_RESET = '1;

    // True when the chunk type is listed and its mask bit is set
    function automatic logic type_dropped(input logic [31:0] chunk_type,
                                          input logic [NumStripTypes-1:0] mask);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < NumStripTypes; i++)
        begin
            if (mask[i] && (chunk_type == STRIP_TYPES[i]))
            begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

endpackage

### rtl/core/png_metadata_chunk_filter.sv
// Results are registered: every kept byte leaves through the output register.
// Input takes one byte per cycle unless byte_stall is high; a kept chunk header gives eight
// results, and the input stalls while the held header bytes drain.
// Reset (rst_n, async, active low): clears parser and output control, drop_mask returns to 63.
// Depends on pmcf_pkg.
module png_metadata_chunk_filter
    import pmcf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    // configuration write channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [5:0] cfg_data,
    // input byte channel
    input  logic       byte_valid,
    output logic       byte_stall,
    input  logic [7:0] in_byte,
    // result channel
    output logic       res_valid,
    input  logic       res_stall,
    output logic [7:0] out_byte,
    output logic       run_last,
    output logic       stream_done
);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_BODY   = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    // parser state
    phase_t                   phase_reg, phase_next;
    logic [2:0]               hdr_idx_reg, hdr_idx_next;
    logic [7:0]               hold_reg [HdrHoldDepth];
    logic [BodyWidth-1:0]     body_reg, body_next;
    logic                     dropping_reg, dropping_next;
    logic                     end_chunk_reg, end_chunk_next;
    logic [NumStripTypes-1:0] drop_mask_reg;

    // output register and pending header bytes
    logic                     res_valid_reg, res_valid_next;
    logic [7:0]               out_byte_reg, out_byte_next;
    logic                     run_last_reg, run_last_next;
    logic                     stream_done_reg, stream_done_next;
    logic [7:0]               pend_reg [HdrHoldDepth];
    logic [7:0]               pend_next [HdrHoldDepth];
    logic [2:0]               pend_cnt_reg, pend_cnt_next;

    logic        byte_fire;
    logic        out_adv;
    logic        hold_we;
    logic        emit;
    logic        emit_burst;
    logic        emit_last;
    logic        emit_done;
    logic [31:0] chunk_type;
    logic [31:0] chunk_len;
    logic        drop_now;

    assign cfg_ready   = 1'b1;
    assign res_valid   = res_valid_reg;
    assign out_byte    = out_byte_reg;
    assign run_last    = run_last_reg;
    assign stream_done = stream_done_reg;

    // output register can take a new result this cycle
    assign out_adv    = !res_valid_reg || !res_stall;
    assign byte_stall = (pend_cnt_reg != 3'd0) || (res_valid_reg && res_stall);
    assign byte_fire  = byte_valid && !byte_stall;

    assign chunk_type = {hold_reg[4], hold_reg[5], hold_reg[6], in_byte};
    assign chunk_len  = {hold_reg[0], hold_reg[1], hold_reg[2], hold_reg[3]};
    assign drop_now   = type_dropped(chunk_type, drop_mask_reg);

    // chunk parser
    always_comb
    begin
        phase_next     = phase_reg;
        hdr_idx_next   = hdr_idx_reg;
        body_next      = body_reg;
        dropping_next  = dropping_reg;
        end_chunk_next = end_chunk_reg;
        hold_we        = 1'b0;
        emit           = 1'b0;
        emit_burst     = 1'b0;
        emit_last      = 1'b0;
        emit_done      = 1'b0;
        if (byte_fire)
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (hdr_idx_reg != 3'(HdrHoldDepth))
                    begin
                        hold_we      = 1'b1;
                        hdr_idx_next = hdr_idx_reg + 3'd1;
                    end
                    else
                    begin
                        hdr_idx_next   = 3'd0;
                        body_next      = {1'b0, chunk_len} + BodyWidth'(4);
                        dropping_next  = drop_now;
                        end_chunk_next = !drop_now && (chunk_type == IEND_TYPE);
                        phase_next     = PH_BODY;
                        emit           = !drop_now;
                        emit_burst     = !drop_now;
                    end
                end
                PH_BODY:
                begin
                    body_next = body_reg - BodyWidth'(1);
                    if (body_next == '0)
                    begin
                        phase_next = end_chunk_reg ? PH_DONE : PH_HEADER;
                    end
                    emit      = !dropping_reg;
                    emit_last = 1'b1;
                    emit_done = (body_next == '0) && end_chunk_reg;
                end
                default:
                begin
                    // stream finished: bytes are swallowed
                end
            endcase
        end
    end

    // output register and header burst drain
    always_comb
    begin
        res_valid_next   = res_valid_reg;
        out_byte_next    = out_byte_reg;
        run_last_next    = run_last_reg;
        stream_done_next = stream_done_reg;
        pend_cnt_next    = pend_cnt_reg;
        for (int i = 0; i < HdrHoldDepth; i++)
        begin
            pend_next[i] = pend_reg[i];
        end
        if (out_adv)
        begin
            if (pend_cnt_reg != 3'd0)
            begin
                res_valid_next   = 1'b1;
                out_byte_next    = pend_reg[0];
                run_last_next    = (pend_cnt_reg == 3'd1);
                stream_done_next = 1'b0;
                pend_cnt_next    = pend_cnt_reg - 3'd1;
                for (int i = 0; i < HdrHoldDepth - 1; i++)
                begin
                    pend_next[i] = pend_reg[i+1];
                end
            end
            else if (emit && emit_burst)
            begin
                res_valid_next   = 1'b1;
                out_byte_next    = hold_reg[0];
                run_last_next    = 1'b0;
                stream_done_next = 1'b0;
                pend_cnt_next    = 3'(HdrHoldDepth);
                for (int i = 0; i < HdrHoldDepth - 1; i++)
                begin
                    pend_next[i] = hold_reg[i+1];
                end
                pend_next[HdrHoldDepth-1] = in_byte;
            end
            else if (emit)
            begin
                res_valid_next   = 1'b1;
                out_byte_next    = in_byte;
                run_last_next    = emit_last;
                stream_done_next = emit_done;
            end
            else
            begin
                res_valid_next = 1'b0;
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_HEADER;
            hdr_idx_reg   <= 3'd0;
            body_reg      <= '0;
            dropping_reg  <= 1'b0;
            end_chunk_reg <= 1'b0;
            drop_mask_reg <= DROP_MASK_RESET;
            res_valid_reg <= 1'b0;
            pend_cnt_reg  <= 3'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            hdr_idx_reg   <= hdr_idx_next;
            body_reg      <= body_next;
            dropping_reg  <= dropping_next;
            end_chunk_reg <= end_chunk_next;
            res_valid_reg <= res_valid_next;
            pend_cnt_reg  <= pend_cnt_next;
            if (cfg_valid && cfg_ready)
            begin
                drop_mask_reg <= cfg_data;
            end
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        out_byte_reg    <= out_byte_next;
        run_last_reg    <= run_last_next;
        stream_done_reg <= stream_done_next;
        for (int i = 0; i < HdrHoldDepth; i++)
        begin
            pend_reg[i] <= pend_next[i];
        end
        if (hold_we)
        begin
            hold_reg[hdr_idx_reg] <= in_byte;
        end
    end

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// Testbench for png_metadata_chunk_filter: feeds a PNG chunk byte stream under random
// sender gaps and receiver stalls, predicts the kept bytes and checks them in order.
// Depends on pmcf_pkg and the png_metadata_chunk_filter RTL.
module testbench
    import pmcf_pkg::*;
();

    localparam int unsigned CycleLimit = 200000;
    localparam int unsigned HoldCycles = 200;
    localparam int unsigned DrainLimit = 5000;
    localparam int unsigned MaxReports = 40;
    localparam int unsigned StreamBytes = 160;
    localparam int unsigned NumPhases = 5;
    localparam logic [31:0] IdatType = 32'h4944_4154;

    typedef enum logic [1:0] {PARSE_HEADER, PARSE_BODY, PARSE_DONE} parse_phase_e;
    typedef enum logic [1:0] {ROW_SILENT, ROW_ECHO, ROW_PREDICT} row_kind_e;
    typedef enum logic [1:0] {END_IEND, END_HUGE, END_CUT} stream_end_e;
    typedef enum logic [1:0] {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       done;
    } kept_byte_t;

    typedef struct packed {
        logic [7:0] val;
        row_kind_e  kind;
    } dir_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [5:0] cfg_data = 6'd0;
    logic       byte_valid = 1'b0;
    logic       byte_stall;
    logic [7:0] in_byte = 8'd0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [7:0] out_byte;
    logic       run_last;
    logic       stream_done;

    // expected output bytes, oldest first
    kept_byte_t kept_q[$];
    kept_byte_t step_q[$];
    logic [7:0] stream_q[$];
    dir_row_t   dir_q[$];

    // parser model state
    parse_phase_e parse_ph;
    logic [2:0]   hdr_cnt;
    logic [7:0]   hdr_bytes [7];
    logic [32:0]  body_left;
    logic         drop_cur;
    logic         iend_cur;
    logic [5:0]   mask_now;

    int unsigned fail_count = 0;
    int unsigned cycle_cnt = 0;
    int unsigned burst_left = 0;
    kept_byte_t  mon_want;

    // receiver state
    rx_mode_e    rx_mode = RX_FREE;
    int unsigned rx_mode_left = 0;
    int unsigned rx_seen = 0;
    int unsigned hold_left = 0;
    logic        hold_used = 1'b0;

    png_metadata_chunk_filter dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .in_byte    (in_byte),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .out_byte   (out_byte),
        .run_last   (run_last),
        .stream_done(stream_done)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
    end

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= MaxReports)
        begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    // Model of the chunk parser: one accepted byte in, its kept bytes into step_q
    function automatic void strip_predict(input logic [7:0] b);
        logic [31:0] ctype;
        logic [31:0] clen;
        logic        drop;
        step_q.delete();
        case (parse_ph)
            PARSE_HEADER:
            begin
                if (hdr_cnt < 3'd7)
                begin
                    hdr_bytes[hdr_cnt] = b;
                    hdr_cnt = hdr_cnt + 3'd1;
                end
                else
                begin
                    clen  = {hdr_bytes[0], hdr_bytes[1], hdr_bytes[2], hdr_bytes[3]};
                    ctype = {hdr_bytes[4], hdr_bytes[5], hdr_bytes[6], b};
                    drop  = 1'b0;
                    for (int i = 0; i < NumStripTypes; i++)
                    begin
                        if (mask_now[i] && (ctype == STRIP_TYPES[i]))
                        begin
                            drop = 1'b1;
                        end
                    end
                    hdr_cnt   = 3'd0;
                    // 33 bits: a length near 2^32 must not wrap
                    body_left = {1'b0, clen} + 33'd4;
                    drop_cur  = drop;
                    iend_cur  = !drop && (ctype == IEND_TYPE);
                    parse_ph  = PARSE_BODY;
                    if (!drop)
                    begin
                        for (int i = 0; i < 7; i++)
                        begin
                            step_q.push_back({hdr_bytes[i], 1'b0, 1'b0});
                        end
                        step_q.push_back({b, 1'b1, 1'b0});
                    end
                end
            end
            PARSE_BODY:
            begin
                body_left = body_left - 33'd1;
                if (body_left == 33'd0)
                begin
                    parse_ph = iend_cur ? PARSE_DONE : PARSE_HEADER;
                end
                if (!drop_cur)
                begin
                    step_q.push_back({b, 1'b1, (body_left == 33'd0) && iend_cur});
                end
            end
            default:
            begin
                // stream finished: bytes are swallowed
            end
        endcase
    endfunction

    // Directed rows: n bytes of v, most significant first
    function automatic void add_rows(input logic [63:0] v, input int n, input row_kind_e kind);
        for (int i = n - 1; i >= 0; i--)
        begin
            dir_q.push_back({v[8*i +: 8], kind});
        end
    endfunction

    function automatic void add_chunk(input logic [31:0] ctype, input logic [31:0] clen,
                                      input int unsigned body_n);
        for (int i = 3; i >= 0; i--)
        begin
            stream_q.push_back(clen[8*i +: 8]);
        end
        for (int i = 3; i >= 0; i--)
        begin
            stream_q.push_back(ctype[8*i +: 8]);
        end
        repeat (body_n)
        begin
            stream_q.push_back(8'($urandom));
        end
    endfunction

    // Mostly strippable types, some near misses and random types; never IEND mid-stream
    function automatic logic [31:0] pick_type();
        logic [31:0] t;
        int unsigned r;
        int unsigned k;
        r = $urandom_range(0, 9);
        k = $urandom_range(0, NumStripTypes - 1);
        if (r <= 5)
        begin
            t = STRIP_TYPES[k];
        end
        else if (r == 6)
        begin
            t = STRIP_TYPES[k];
            r = $urandom_range(0, 3);
            t[8*r +: 8] = t[8*r +: 8] ^ 8'($urandom_range(1, 255));
        end
        else
        begin
            t = $urandom;
        end
        if (t == IEND_TYPE)
        begin
            t = IdatType;
        end
        return t;
    endfunction

    // Sender: bursts of random length separated by random gaps
    task automatic push_byte(input logic [7:0] b);
        if (burst_left == 0)
        begin
            byte_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            burst_left = $urandom_range(1, 40);
        end
        byte_valid <= 1'b1;
        in_byte    <= b;
        @(posedge clk);
        while (byte_stall)
        begin
            @(posedge clk);
        end
        burst_left--;
    endtask

    // Mask write only once the block has drained
    task automatic write_drop_mask(input logic [5:0] m);
        byte_valid <= 1'b0;
        while (kept_q.size() != 0)
        begin
            @(posedge clk);
        end
        // dropped bytes leave nothing to wait for; give the pipe time to settle
        repeat (3) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= m;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
        mask_now = m;
    endtask

    // Receiver: changing stall patterns, plus one long hold-off
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            rx_seen <= rx_seen + 1;
        end
        if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else if (!hold_used && rx_seen == 30)
        begin
            hold_used <= 1'b1;
            hold_left <= HoldCycles;
            res_stall <= 1'b1;
        end
        else
        begin
            if (rx_mode_left == 0)
            begin
                rx_mode_left <= $urandom_range(16, 96);
                rx_mode      <= rx_mode_e'($urandom_range(0, 3));
            end
            else
            begin
                rx_mode_left <= rx_mode_left - 1;
            end
            case (rx_mode)
                RX_FREE:     res_stall <= 1'b0;
                RX_LIGHT:    res_stall <= ($urandom_range(0, 3) == 0);
                RX_HEAVY:    res_stall <= ($urandom_range(0, 9) < 7);
                default:     res_stall <= ((cycle_cnt % 5) < 2);
            endcase
        end
    end

    // Result checker: every result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && res_valid && !res_stall)
        begin
            if (kept_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected result: byte %02h last %0b done %0b",
                                          out_byte, run_last, stream_done));
            end
            else
            begin
                mon_want = kept_q.pop_front();
                if (out_byte !== mon_want.data)
                begin
                    report_mismatch($sformatf("out_byte %02h, expected %02h",
                                              out_byte, mon_want.data));
                end
                if (run_last !== mon_want.last)
                begin
                    report_mismatch($sformatf("run_last %0b, expected %0b on byte %02h",
                                              run_last, mon_want.last, mon_want.data));
                end
                if (stream_done !== mon_want.done)
                begin
                    report_mismatch($sformatf("stream_done %0b, expected %0b on byte %02h",
                                              stream_done, mon_want.done, mon_want.data));
                end
            end
        end
    end

    // Timeout
    initial
    begin
        wait (cycle_cnt >= CycleLimit);
        $display("ERROR: run exceeded %0d cycles", CycleLimit);
        $display("Test completed with failures");
        $finish;
    end

    // Stimulus
    initial
    begin
        logic [7:0]  b;
        logic [5:0]  m;
        logic [31:0] clen;
        int unsigned total;
        int unsigned n_phase;
        int unsigned drain;
        int unsigned r;
        stream_end_e ending;

        parse_ph  = PARSE_HEADER;
        hdr_cnt   = 3'd0;
        body_left = 33'd0;
        drop_cur  = 1'b0;
        iend_cur  = 1'b0;
        mask_now  = DROP_MASK_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table, reset mask: a tEXt chunk of length 0 is dropped whole,
        // then an unknown type with extreme bytes passes through
        add_rows(64'h0000_0000_7445_5874, 8, ROW_SILENT);
        add_rows(64'hDEAD_BEEF, 4, ROW_SILENT);
        add_rows(64'h0000_0001_FF00_FF, 7, ROW_SILENT);
        add_rows(64'h00, 1, ROW_PREDICT);
        add_rows(64'hFF_00FF_00FF, 5, ROW_ECHO);
        foreach (dir_q[i])
        begin
            push_byte(dir_q[i].val);
            strip_predict(dir_q[i].val);
            case (dir_q[i].kind)
                ROW_ECHO:
                begin
                    kept_q.push_back({dir_q[i].val, 1'b1, 1'b0});
                end
                ROW_PREDICT:
                begin
                    foreach (step_q[k])
                    begin
                        kept_q.push_back(step_q[k]);
                    end
                end
                default:
                begin
                end
            endcase
        end

        // Random chunk stream, short bodies mostly
        while (stream_q.size() < StreamBytes)
        begin
            clen = ($urandom_range(0, 5) == 0) ? $urandom_range(7, 24) : $urandom_range(0, 6);
            add_chunk(pick_type(), clen, clen + 4);
        end

        // The stream ends in one of three ways
        r = $urandom_range(0, 3);
        ending = (r < 2) ? END_IEND : ((r == 2) ? END_HUGE : END_CUT);
        case (ending)
            END_IEND:
            begin
                clen = $urandom_range(0, 3);
                add_chunk(IEND_TYPE, clen, clen + 4);
                // trailing bytes after IEND must vanish
                repeat (6)
                begin
                    stream_q.push_back(8'($urandom));
                end
            end
            END_HUGE:
            begin
                // length near 2^32: body must keep flowing, no wrap to a short chunk
                clen = 32'hFFFF_FFFF - $urandom_range(0, 3);
                add_chunk(pick_type(), clen, 24);
            end
            default:
            begin
                // header cut short: nothing may come out for it
                repeat ($urandom_range(1, 7))
                begin
                    stream_q.push_back(8'($urandom));
                end
            end
        endcase

        // Phases under different masks; boundaries land anywhere in a chunk
        total = stream_q.size();
        for (int p = 0; p < NumPhases; p++)
        begin
            case (p)
                0:       m = 6'h00;
                1:       m = 6'h3F;
                default: m = 6'($urandom);
            endcase
            write_drop_mask(m);
            n_phase = (p == NumPhases - 1) ? stream_q.size() : total / NumPhases;
            repeat (n_phase)
            begin
                b = stream_q.pop_front();
                push_byte(b);
                strip_predict(b);
                foreach (step_q[k])
                begin
                    kept_q.push_back(step_q[k]);
                end
            end
        end
        byte_valid <= 1'b0;

        // Drain and settle
        drain = 0;
        while (kept_q.size() != 0 && drain < DrainLimit)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (10) @(posedge clk);
        if (kept_q.size() != 0)
        begin
            report_mismatch($sformatf("%0d expected bytes never came out", kept_q.size()));
        end

        if (fail_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
